>>> hw/rtl/dst_pkg.sv
// ----------------------------------------------------------------------------
// dst_pkg
// Shared types and constants of the device scan table.
// ----------------------------------------------------------------------------
package dst_pkg;

    localparam int ADDR_W        = 48;
    localparam int KIND_W        = 4;
    localparam int STR_W         = 8;
    localparam int CMD_W         = 2;
    localparam int STATUS_W      = 3;
    localparam int SLOT_W        = 6;
    localparam int DEFAULT_DEPTH = 64;

    localparam logic signed [STR_W-1:0] FLOOR_RESET = -8'sd127;

    typedef enum logic [CMD_W-1:0] {
        CMD_REPORT  = 2'd0,
        CMD_CLOSEST = 2'd1,
        CMD_DRAIN   = 2'd2,
        CMD_CLEAR   = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED    = 3'd0,
        ST_UPDATED  = 3'd1,
        ST_REJECTED = 3'd2,
        ST_READOUT  = 3'd3,
        ST_CLEARED  = 3'd4,
        ST_CLOSEST  = 3'd5,
        ST_EMPTY    = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_FIN,
        S_DRD,
        S_DOUT
    } t_state;

    typedef struct packed {
        logic        [ADDR_W-1:0] addr;
        logic        [KIND_W-1:0] kind;
        logic signed [STR_W-1:0]  strength;
    } t_entry;

    typedef struct packed {
        t_status           status;
        logic [SLOT_W-1:0] slot;
        t_entry            entry;
        logic              last;
    } t_result;

endpackage

>>> hw/rtl/dst_entry_ram.sv
// ----------------------------------------------------------------------------
// dst_entry_ram
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dst_entry_ram #(
    parameter int TABLE_DEPTH = dst_pkg::DEFAULT_DEPTH,
    parameter int IDX_W       = $clog2(TABLE_DEPTH)
) (
    input  logic                i_clk,
    input  logic                i_wr_en,
    input  logic [IDX_W-1:0]    i_wr_addr,
    input  dst_pkg::t_entry     i_wr_data,
    input  logic                i_rd_en,
    input  logic [IDX_W-1:0]    i_rd_addr,
    output dst_pkg::t_entry     o_rd_data
);

    dst_pkg::t_entry r_mem [TABLE_DEPTH];
    dst_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hw/rtl/dedup_scan_table.sv
// ----------------------------------------------------------------------------
// dedup_scan_table
// Deduplicating table of radio devices keyed by address, with a strength
// floor, closest-device query, drain and clear.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake                   | payload
//  ----------+-----------+-----------------------------+-------------------------------
//  request   | in        | i_in_valid / o_in_ready     | cmd, dev_addr, dev_kind, strength
//  result    | out       | o_out_valid / i_out_ready   | status, slot, addr, kind, strength, last
//  config    | in        | i_cfg_we                    | i_cfg_data (strength floor)
//
//  Report and closest: the result waits on the walk over the entry memory (one read
//  a cycle, registered read data). Reject, clear and empty answer without a walk.
//  Drain: for each filled entry, one memory read then one result.
//  Reset: synchronous; the table is empty at once (fill count), no clearing pass.
//  A full result register holds the sequencer until the result is taken; a new
//  request is taken while the last result still waits.
// ----------------------------------------------------------------------------
module dedup_scan_table #(
    parameter int TABLE_DEPTH = dst_pkg::DEFAULT_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic signed [dst_pkg::STR_W-1:0]  i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [dst_pkg::CMD_W-1:0]         i_cmd,
    input  logic [dst_pkg::ADDR_W-1:0]        i_dev_addr,
    input  logic [dst_pkg::KIND_W-1:0]        i_dev_kind,
    input  logic signed [dst_pkg::STR_W-1:0]  i_strength,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [dst_pkg::STATUS_W-1:0]      o_status,
    output logic [dst_pkg::SLOT_W-1:0]        o_slot,
    output logic [dst_pkg::ADDR_W-1:0]        o_out_addr,
    output logic [dst_pkg::KIND_W-1:0]        o_out_kind,
    output logic signed [dst_pkg::STR_W-1:0]  o_out_strength,
    output logic                              o_last
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int FW = $clog2(TABLE_DEPTH + 1);
    localparam logic [FW-1:0] FILL_FULL = FW'(TABLE_DEPTH);

    dst_pkg::t_state  r_state, n_state;
    dst_pkg::t_cmd    r_cmd, n_cmd;
    dst_pkg::t_entry  r_req, n_req;
    dst_pkg::t_entry  r_best, n_best;
    logic [IW-1:0]    r_best_idx, n_best_idx;
    logic             r_hit, n_hit;
    logic [FW-1:0]    r_idx, n_idx;
    logic             r_pend, n_pend;
    logic [IW-1:0]    r_pidx, n_pidx;
    logic [FW-1:0]    r_fill, n_fill;
    logic [IW-1:0]    r_wp, n_wp;
    logic signed [dst_pkg::STR_W-1:0] r_floor;
    logic             r_o_valid;
    dst_pkg::t_result r_res, n_res;
    logic             res_load;

    logic             rd_en, wr_en;
    logic [IW-1:0]    rd_addr, wr_addr;
    dst_pkg::t_entry  rd_data, wr_data;

    logic             in_accept, o_free;
    logic [FW-1:0]    wp_next;

    dst_entry_ram #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_in_ready = (r_state == dst_pkg::S_IDLE);
    assign in_accept  = i_in_valid && o_in_ready;
    assign o_free     = !r_o_valid || i_out_ready;
    assign wp_next    = FW'(r_wp) + FW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= dst_pkg::S_IDLE;
            r_fill    <= '0;
            r_wp      <= '0;
            r_floor   <= dst_pkg::FLOOR_RESET;
            r_o_valid <= 1'b0;
            r_pend    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_wp    <= n_wp;
            r_pend  <= n_pend;
            if (i_cfg_we) begin
                r_floor <= i_cfg_data;
            end
            if (res_load) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_req      <= n_req;
        r_best     <= n_best;
        r_best_idx <= n_best_idx;
        r_hit      <= n_hit;
        r_idx      <= n_idx;
        r_pidx     <= n_pidx;
        if (res_load) begin
            r_res <= n_res;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_req      = r_req;
        n_best     = r_best;
        n_best_idx = r_best_idx;
        n_hit      = r_hit;
        n_idx      = r_idx;
        n_pend     = 1'b0;
        n_pidx     = r_pidx;
        n_fill     = r_fill;
        n_wp       = r_wp;
        n_res      = '0;
        res_load   = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = r_idx[IW-1:0];
        wr_en      = 1'b0;
        wr_addr    = r_wp;
        wr_data    = r_req;

        unique case (r_state)
            dst_pkg::S_IDLE: begin
                if (in_accept) begin
                    n_cmd          = dst_pkg::t_cmd'(i_cmd);
                    n_req.addr     = i_dev_addr;
                    n_req.kind     = i_dev_kind;
                    n_req.strength = i_strength;
                    n_state        = dst_pkg::S_START;
                end
            end

            dst_pkg::S_START: begin
                n_idx = '0;
                n_hit = 1'b0;
                priority if (r_cmd == dst_pkg::CMD_REPORT
                             && r_req.strength <= r_floor) begin
                    if (o_free) begin
                        res_load     = 1'b1;
                        n_res.status = dst_pkg::ST_REJECTED;
                        n_res.entry  = r_req;
                        n_res.last   = 1'b1;
                        n_state      = dst_pkg::S_IDLE;
                    end
                end else if (r_cmd == dst_pkg::CMD_REPORT) begin
                    n_state = dst_pkg::S_SCAN;
                end else if (r_cmd == dst_pkg::CMD_CLEAR || r_fill == '0) begin
                    if (o_free) begin
                        res_load     = 1'b1;
                        n_res.status = (r_cmd == dst_pkg::CMD_CLEAR) ?
                                       dst_pkg::ST_CLEARED : dst_pkg::ST_EMPTY;
                        n_res.last   = 1'b1;
                        n_state      = dst_pkg::S_IDLE;
                        if (r_cmd == dst_pkg::CMD_CLEAR) begin
                            n_fill = '0;
                            n_wp   = '0;
                        end
                    end
                end else if (r_cmd == dst_pkg::CMD_CLOSEST) begin
                    n_state = dst_pkg::S_SCAN;
                end else begin
                    n_state = dst_pkg::S_DRD;
                end
            end

            dst_pkg::S_SCAN: begin
                // issue the next read
                if (r_idx < r_fill) begin
                    rd_en  = 1'b1;
                    n_idx  = r_idx + FW'(1);
                    n_pend = 1'b1;
                    n_pidx = r_idx[IW-1:0];
                end
                // evaluate the entry read last cycle
                if (r_pend) begin
                    if (r_cmd == dst_pkg::CMD_REPORT) begin
                        if (rd_data.addr == r_req.addr) begin
                            n_hit      = 1'b1;
                            n_best     = rd_data;
                            n_best_idx = r_pidx;
                            n_state    = dst_pkg::S_FIN;
                        end
                    end else if (r_pidx == '0
                                 || $signed(rd_data.strength) > $signed(r_best.strength)) begin
                        n_best     = rd_data;
                        n_best_idx = r_pidx;
                    end
                end else if (r_idx >= r_fill) begin
                    n_state = dst_pkg::S_FIN;
                end
            end

            dst_pkg::S_FIN: begin
                if (o_free) begin
                    res_load   = 1'b1;
                    n_res.last = 1'b1;
                    n_state    = dst_pkg::S_IDLE;
                    priority if (r_cmd == dst_pkg::CMD_CLOSEST) begin
                        n_res.status = dst_pkg::ST_CLOSEST;
                        n_res.slot   = dst_pkg::SLOT_W'(r_best_idx);
                        n_res.entry  = r_best;
                    end else if (r_hit) begin
                        wr_en                = 1'b1;
                        wr_addr              = r_best_idx;
                        wr_data              = r_best;
                        wr_data.strength     = r_req.strength;
                        n_res.status         = dst_pkg::ST_UPDATED;
                        n_res.slot           = dst_pkg::SLOT_W'(r_best_idx);
                        n_res.entry          = r_best;
                        n_res.entry.strength = r_req.strength;
                    end else begin
                        wr_en        = 1'b1;
                        n_res.status = dst_pkg::ST_ADDED;
                        n_res.slot   = dst_pkg::SLOT_W'(r_wp);
                        n_res.entry  = r_req;
                        if (wp_next < FILL_FULL) begin
                            n_wp = wp_next[IW-1:0];
                            if (wp_next > r_fill) begin
                                n_fill = wp_next;
                            end
                        end else begin
                            n_wp   = '0;
                            n_fill = FILL_FULL;
                        end
                    end
                end
            end

            dst_pkg::S_DRD: begin
                rd_en   = 1'b1;
                n_state = dst_pkg::S_DOUT;
            end

            dst_pkg::S_DOUT: begin
                if (o_free) begin
                    res_load     = 1'b1;
                    n_res.status = dst_pkg::ST_READOUT;
                    n_res.slot   = dst_pkg::SLOT_W'(r_idx[IW-1:0]);
                    n_res.entry  = rd_data;
                    n_res.last   = ((r_idx + FW'(1)) == r_fill);
                    if (n_res.last) begin
                        n_fill  = '0;
                        n_wp    = '0;
                        n_state = dst_pkg::S_IDLE;
                    end else begin
                        n_idx   = r_idx + FW'(1);
                        n_state = dst_pkg::S_DRD;
                    end
                end
            end

            default: begin
                n_state = dst_pkg::S_IDLE;
            end
        endcase
    end

    assign o_out_valid    = r_o_valid;
    assign o_status       = r_res.status;
    assign o_slot         = r_res.slot;
    assign o_out_addr     = r_res.entry.addr;
    assign o_out_kind     = r_res.entry.kind;
    assign o_out_strength = r_res.entry.strength;
    assign o_last         = r_res.last;

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_FULL)
        else $error("fill count beyond table depth");

    a_wp_tracks_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill != FILL_FULL) |-> (FW'(r_wp) == r_fill))
        else $error("write pointer and fill count out of step");

    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_load |-> (!r_o_valid || i_out_ready))
        else $error("pending result overwritten");

    a_request_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == dst_pkg::S_START))
        else $error("accepted request not started");
`endif

endmodule
